// ----- hw/rtl/adsr_pkg.sv -----
package adsr_pkg;

	localparam int COUNT_W = 24;
	localparam int LEVEL_W = 16;
	localparam int TICK_W = 16;
	localparam int ACC_W = COUNT_W + LEVEL_W;
	localparam int STEP_W = $clog2(LEVEL_W);
	localparam int CFG_IDX_W = 3;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = {LEVEL_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

	typedef enum logic [2:0] {
		PH_ATTACK = 3'd0,
		PH_DECAY = 3'd1,
		PH_SUSTAIN = 3'd2,
		PH_RELEASE = 3'd3,
		PH_IDLE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_GATE_ON = 2'd1,
		REQ_GATE_OFF = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] attack;
		logic [COUNT_W-1:0] decay;
		logic [COUNT_W-1:0] rel;
		logic [LEVEL_W-1:0] sustain;
		logic enable;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic [LEVEL_W-1:0] y0;
		logic [LEVEL_W-1:0] y1;
		logic [COUNT_W-1:0] len;
		logic [COUNT_W-1:0] cnt;
	} interp_req_t;

	typedef struct packed {
		logic done;
		logic [LEVEL_W-1:0] quot;
	} interp_res_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		phase_t phase;
	} res_t;

	function automatic phase_t next_phase(phase_t p);
		phase_t n;
		n = p;
		case (p)
			PH_ATTACK: n = PH_DECAY;
			PH_DECAY: n = PH_SUSTAIN;
			PH_RELEASE: n = PH_IDLE;
			default: n = p;
		endcase
		return n;
	endfunction

endpackage

// ----- hw/rtl/adsr_envelope_generator.sv -----
// the time from input beat to output beat grows with the interpolations that the level needs: none,
// one, or two for a gate off that interpolates twice
// interpolation runs a 16-step bit-serial multiply then a 16-step bit-serial divide
// one item in flight, so a new input beat is not accepted until the previous one is through;
// s_tready rises again once the result moves to the output register
// reset clears phase to attack, counts and release level to zero, enable to one
module adsr_envelope_generator (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [adsr_pkg::IN_TDATA_W-1:0] s_tdata, // tick_count
	input logic [1:0] s_tuser, // req_type
	output logic m_tvalid,
	input logic m_tready,
	output logic [adsr_pkg::OUT_TDATA_W-1:0] m_tdata, // level, phase
	input logic cfg_wr_en,
	input logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [adsr_pkg::COUNT_W-1:0] cfg_data
);
	import adsr_pkg::*;

	cfg_t cfg_q;
	interp_req_t ireq;
	interp_res_t ires;
	res_t res;
	logic res_valid;
	logic res_ready;
	logic m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack <= '0;
			cfg_q.decay <= '0;
			cfg_q.rel <= '0;
			cfg_q.sustain <= '0;
			cfg_q.enable <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ATTACK: cfg_q.attack <= cfg_data;
				REG_DECAY: cfg_q.decay <= cfg_data;
				REG_RELEASE: cfg_q.rel <= cfg_data;
				REG_SUSTAIN: cfg_q.sustain <= cfg_data[LEVEL_W-1:0];
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	adsr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req(req_t'(s_tuser)),
		.in_ticks(s_tdata[TICK_W-1:0]),
		.ireq(ireq),
		.ires(ires),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	adsr_interp u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.ireq(ireq),
		.ires(ires)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {{(OUT_TDATA_W - LEVEL_W - 3){1'b0}}, res.phase, res.level};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// ----- hw/rtl/adsr_interp.sv -----
module adsr_interp (
	input logic clk,
	input logic arst_n,
	input adsr_pkg::interp_req_t ireq,
	output adsr_pkg::interp_res_t ires
);
	import adsr_pkg::*;

	typedef enum logic [1:0] {I_IDLE, I_MUL, I_DIV} istate_t;

	istate_t state_q;
	logic [STEP_W-1:0] step_q;
	logic done_q;
	logic [ACC_W-1:0] acc_q;
	logic [LEVEL_W-1:0] y0_q;
	logic [LEVEL_W-1:0] y1_q;
	logic [COUNT_W-1:0] lmc_q;
	logic [COUNT_W-1:0] c_q;
	logic [COUNT_W-1:0] len_q;

	logic [COUNT_W-1:0] addend;
	logic [COUNT_W:0] trial;
	logic [COUNT_W:0] diff;
	logic ge;
	logic [COUNT_W-1:0] new_rem;

	// one weight bit of each endpoint per cycle, msb first
	always_comb begin
		case ({y0_q[LEVEL_W-1], y1_q[LEVEL_W-1]})
			2'b10: addend = lmc_q;
			2'b01: addend = c_q;
			2'b11: addend = len_q;
			default: addend = '0;
		endcase
	end

	// restoring divide, one quotient bit per cycle
	always_comb begin
		trial = {acc_q[ACC_W-1:LEVEL_W], acc_q[LEVEL_W-1]};
		diff = trial - {1'b0, len_q};
		ge = (trial >= {1'b0, len_q});
		new_rem = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				I_IDLE: begin
					if (ireq.start) begin
						state_q <= I_MUL;
						step_q <= STEP_W'(LEVEL_W - 1);
					end
				end
				I_MUL: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= I_DIV;
						step_q <= STEP_W'(LEVEL_W - 1);
					end
				end
				I_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= I_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= I_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			I_IDLE: begin
				if (ireq.start) begin
					acc_q <= '0;
					y0_q <= ireq.y0;
					y1_q <= ireq.y1;
					lmc_q <= ireq.len - ireq.cnt;
					c_q <= ireq.cnt;
					len_q <= ireq.len;
				end
			end
			I_MUL: begin
				acc_q <= {acc_q[ACC_W-2:0], 1'b0} + {{LEVEL_W{1'b0}}, addend};
				y0_q <= {y0_q[LEVEL_W-2:0], 1'b0};
				y1_q <= {y1_q[LEVEL_W-2:0], 1'b0};
			end
			I_DIV: begin
				acc_q <= {new_rem, acc_q[LEVEL_W-2:0], ge};
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign ires.done = done_q;
	assign ires.quot = acc_q[LEVEL_W-1:0];

endmodule

// ----- hw/rtl/adsr_ctrl.sv -----
module adsr_ctrl (
	input logic clk,
	input logic arst_n,
	input adsr_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input adsr_pkg::req_t in_req,
	input logic [adsr_pkg::TICK_W-1:0] in_ticks,
	output adsr_pkg::interp_req_t ireq,
	input adsr_pkg::interp_res_t ires,
	output logic res_valid,
	input logic res_ready,
	output adsr_pkg::res_t res
);
	import adsr_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_TICK, S_LVL, S_WAIT, S_OUT} state_t;

	state_t state_q;
	phase_t phase_q;
	logic [COUNT_W-1:0] count_q;
	logic [LEVEL_W-1:0] rls_q;
	logic [TICK_W-1:0] rem_q;
	logic gate_off_q;
	logic [LEVEL_W-1:0] level_q;

	logic [COUNT_W-1:0] len_cur;
	logic [COUNT_W-1:0] cnt_clamp;
	logic [COUNT_W-1:0] left;
	logic [COUNT_W-1:0] rem_ext;
	logic is_run;
	logic tick_end;
	logic direct;
	logic [LEVEL_W-1:0] dval;
	logic [LEVEL_W-1:0] y0;
	logic [LEVEL_W-1:0] y1;
	logic lvl_rdy;
	logic [LEVEL_W-1:0] lvl_val;

	always_comb begin
		case (phase_q)
			PH_ATTACK: len_cur = cfg.attack;
			PH_DECAY: len_cur = cfg.decay;
			PH_RELEASE: len_cur = cfg.rel;
			default: len_cur = '0;
		endcase
	end

	assign cnt_clamp = (count_q > len_cur) ? len_cur : count_q;
	assign left = (count_q >= len_cur) ? '0 : (len_cur - count_q);
	assign rem_ext = {{(COUNT_W - TICK_W){1'b0}}, rem_q};
	assign is_run = (phase_q == PH_ATTACK) || (phase_q == PH_DECAY) ||
		(phase_q == PH_RELEASE);
	assign tick_end = (rem_q == '0) || !is_run;

	// level of the present state, either known at once or interpolated
	always_comb begin
		direct = 1'b1;
		dval = '0;
		y0 = '0;
		y1 = '0;
		if (!cfg.enable) begin
			dval = FULL_LEVEL;
		end else begin
			case (phase_q)
				PH_ATTACK: begin
					if (len_cur == '0) dval = FULL_LEVEL;
					else begin
						direct = 1'b0;
						y1 = FULL_LEVEL;
					end
				end
				PH_DECAY: begin
					if (len_cur == '0) dval = cfg.sustain;
					else begin
						direct = 1'b0;
						y0 = FULL_LEVEL;
						y1 = cfg.sustain;
					end
				end
				PH_SUSTAIN: dval = cfg.sustain;
				PH_RELEASE: begin
					if (len_cur != '0) begin
						direct = 1'b0;
						y0 = rls_q;
					end
				end
				default: dval = '0;
			endcase
		end
	end

	assign lvl_rdy = ((state_q == S_LVL) && direct) || ((state_q == S_WAIT) && ires.done);
	assign lvl_val = (state_q == S_WAIT) ? ires.quot : dval;

	assign ireq.start = (state_q == S_LVL) && !direct;
	assign ireq.y0 = y0;
	assign ireq.y1 = y1;
	assign ireq.len = len_cur;
	assign ireq.cnt = cnt_clamp;

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res.level = level_q;
	assign res.phase = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_ATTACK;
			count_q <= '0;
			rls_q <= '0;
			rem_q <= '0;
			gate_off_q <= 1'b0;
			level_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_req)
							REQ_TICK: begin
								rem_q <= in_ticks;
								state_q <= S_TICK;
							end
							REQ_GATE_ON: begin
								phase_q <= PH_ATTACK;
								count_q <= '0;
								state_q <= S_LVL;
							end
							REQ_GATE_OFF: begin
								gate_off_q <= (phase_q != PH_IDLE);
								state_q <= S_LVL;
							end
							default: state_q <= S_LVL;
						endcase
					end
				end
				// one phase step per cycle
				S_TICK: begin
					if (tick_end) begin
						state_q <= S_LVL;
					end else if (len_cur == '0) begin
						phase_q <= next_phase(phase_q);
						count_q <= '0;
					end else if (rem_ext < left) begin
						count_q <= count_q + rem_ext;
						rem_q <= '0;
					end else begin
						rem_q <= rem_q - left[TICK_W-1:0];
						phase_q <= next_phase(phase_q);
						count_q <= '0;
					end
				end
				S_LVL, S_WAIT: begin
					if (lvl_rdy) begin
						if (gate_off_q) begin
							rls_q <= lvl_val;
							phase_q <= PH_RELEASE;
							count_q <= '0;
							gate_off_q <= 1'b0;
							state_q <= S_LVL;
						end else begin
							level_q <= lvl_val;
							state_q <= S_OUT;
						end
					end else if (state_q == S_LVL) begin
						state_q <= S_WAIT;
					end
				end
				S_OUT: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_hold_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SUSTAIN || phase_q == PH_IDLE) |-> count_q == '0)
		else $error("count nonzero in a held phase");

	a_tick_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && !is_run) |=> state_q == S_LVL)
		else $error("tick kept stepping past a held phase");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ires.done |-> state_q == S_WAIT)
		else $error("interpolation result with nobody waiting");

	a_quot_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ires.done |-> (ires.quot <= y0 || ires.quot <= y1))
		else $error("interpolated level outside its endpoints");

endmodule
